// ----- src/icas_pkg.sv -----
// shared constants, control structs and elaboration-time table functions
// for the image column additive synthesiser; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package icas_pkg;

    localparam int ROWS_DEFAULT            = 64;
    localparam int SINE_TABLE_BITS_DEFAULT = 10;

    localparam int ROW_FIELD_W    = 6;
    localparam int PIXEL_W        = 8;
    localparam int INDEX_W        = 9;
    localparam int SAMPLE_W       = 20;
    localparam int LEVEL_W        = 4;
    localparam int SINE_MAG_W     = 15;
    localparam int PHASE_W        = 32;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    localparam logic [63:0] TONE_A_HZ     = 64'd440;
    localparam logic [63:0] AUDIO_RATE    = 64'd8000;
    localparam int unsigned TONE_A_INDEX  = 31;
    localparam logic [63:0] SEMI_UP_Q31   = 64'd2275179671;
    localparam logic [63:0] SEMI_DOWN_Q32 = 64'd4053909305;
    localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;
    localparam logic [63:0] SINE_PEAK     = 64'd32767;
    localparam logic [63:0] LOW32         = 64'h0000_0000_FFFF_FFFF;
    localparam int          LEVEL_MAX     = 15;
    localparam int          SINE_MAX      = 32767;

    typedef struct packed {
        logic load;
        logic start;
        logic issue;
        logic div_abs;
        logic div_mul;
        logic div_back;
        logic push;
    } icas_cmd_t;

    typedef struct packed {
        logic last_row;
        logic busy;
    } icas_status_t;

    // phase step of tone m in cycles per audio sample, q0.32
    function automatic logic [31:0] tone_step(input int unsigned m);
        logic [63:0] s;
        int unsigned k;
        s = (TONE_A_HZ << 32) / AUDIO_RATE;
        if (m >= TONE_A_INDEX)
        begin
            for (k = TONE_A_INDEX; k < m; k++)
            begin
                s = ((s * SEMI_UP_Q31 + (64'd1 << 30)) >> 31) & LOW32;
            end
        end
        else
        begin
            for (k = m; k < TONE_A_INDEX; k++)
            begin
                s = ((s * SEMI_DOWN_Q32 + (64'd1 << 31)) >> 32) & LOW32;
            end
        end
        return s[31:0];
    endfunction

    // quarter wave entry q of a table with 2^tbits entries, q0.15 magnitude
    function automatic logic [14:0] quarter_sine(input int unsigned q,
                                                 input int unsigned tbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        logic [63:0] t;
        int unsigned n;
        x    = (HALF_PI_Q30 * 64'(q)) >> (tbits - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (n = 1; n <= 5; n++)
        begin
            t = (term * x2) >> 30;
            case (n)
                1:       term = t / 64'd6;
                2:       term = t / 64'd20;
                3:       term = t / 64'd42;
                4:       term = t / 64'd72;
                default: term = t / 64'd110;
            endcase
            if (n[0])
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        v = (sum * SINE_PEAK + (64'd1 << 29)) >> 30;
        if (v > SINE_PEAK)
        begin
            v = SINE_PEAK;
        end
        return v[14:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/icas_if.sv -----
// valid/ready channel interfaces for pixel/sample requests and audio results
// depends on icas_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface icas_item_if;
    logic                                valid;
    logic                                ready;
    logic                                mode;
    logic [icas_pkg::ROW_FIELD_W-1:0]    row;
    logic [icas_pkg::PIXEL_W-1:0]        pixel;
    logic [icas_pkg::INDEX_W-1:0]        sample_index;

    modport source (output valid, output mode, output row, output pixel,
                    output sample_index, input ready);
    modport sink (input valid, input mode, input row, input pixel,
                  input sample_index, output ready);
endinterface

interface icas_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [icas_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ----- src/icas_ctrl.sv -----
// controller: sequences the row walk, pipeline drain, divide and result hand-off
// depends on icas_pkg for command and status structs
`timescale 1ns / 1ps
`default_nettype none

module icas_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_mode,
    output logic                      in_ready,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    input  wire icas_pkg::icas_status_t status,
    output icas_pkg::icas_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DIV_ABS,
        ST_DIV_MUL,
        ST_DIV_BACK,
        ST_PUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   in_fire;
    logic   slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_mode == icas_pkg::MODE_SAMPLE)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                if (status.last_row)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.busy)
                begin
                    state_next = ST_DIV_ABS;
                end
            end
            ST_DIV_ABS:
            begin
                cmd.div_abs = 1'b1;
                state_next  = ST_DIV_MUL;
            end
            ST_DIV_MUL:
            begin
                cmd.div_mul = 1'b1;
                state_next  = ST_DIV_BACK;
            end
            ST_DIV_BACK:
            begin
                cmd.div_back = 1'b1;
                state_next   = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (slot_free)
                begin
                    cmd.push       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/icas_datapath.sv -----
// datapath: level store, tone step table, phase multiply, sine rom,
// level product, accumulator and divide by row count; depends on icas_pkg
`timescale 1ns / 1ps
`default_nettype none

module icas_datapath
#(
    parameter int ROWS            = icas_pkg::ROWS_DEFAULT,
    parameter int SINE_TABLE_BITS = icas_pkg::SINE_TABLE_BITS_DEFAULT
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire icas_pkg::icas_cmd_t                   cmd,
    output icas_pkg::icas_status_t                     status,
    input  wire logic [icas_pkg::ROW_FIELD_W-1:0]      row,
    input  wire logic [icas_pkg::PIXEL_W-1:0]          pixel,
    input  wire logic [icas_pkg::INDEX_W-1:0]          sample_index,
    output logic signed [icas_pkg::SAMPLE_W-1:0]       sample
);

    localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROWX_W   = ROW_W + icas_pkg::ROW_FIELD_W;
    localparam int IDX1_W   = icas_pkg::INDEX_W + 1;
    localparam int PPROD_W  = icas_pkg::PHASE_W + IDX1_W;
    localparam int QSIZE    = 1 << (SINE_TABLE_BITS - 2);
    localparam int QA_W     = SINE_TABLE_BITS - 1;
    localparam int LPROD_W  = icas_pkg::LEVEL_W + icas_pkg::SINE_MAG_W;
    localparam int PROD_W   = LPROD_W + 1;
    localparam int ACC_W    =
        $clog2(ROWS * icas_pkg::LEVEL_MAX * icas_pkg::SINE_MAX + 1) + 1;
    localparam int DIV_K    = ACC_W - 1;
    localparam logic [DIV_K-1:0] RECIP = DIV_K'((64'd1 << DIV_K) / ROWS);

    // constant tables
    logic [31:0]                       step_tab [ROWS];
    logic [icas_pkg::SINE_MAG_W-1:0]   quarter_rom [QSIZE+1];

    for (genvar g = 0; g < ROWS; g++)
    begin : g_step
        assign step_tab[g] = icas_pkg::tone_step(ROWS - 1 - g);
    end

    for (genvar g = 0; g <= QSIZE; g++)
    begin : g_sine
        assign quarter_rom[g] = icas_pkg::quarter_sine(g, SINE_TABLE_BITS);
    end

    // level store
    logic [icas_pkg::LEVEL_W-1:0] lvl_mem [ROWS];
    logic [ROWS-1:0]              lvl_vld_reg;
    logic [ROWX_W-1:0]            row_wide;
    logic                         row_in_range;
    logic [ROW_W-1:0]             wr_idx;

    assign row_wide     = ROWX_W'(row);
    assign row_in_range = row_wide < ROWX_W'(ROWS);
    assign wr_idx       = row_wide[ROW_W-1:0];

    // row walk and pipeline registers
    logic [IDX1_W-1:0]                 idx1_reg;
    logic [ROW_W-1:0]                  row_cnt_reg;
    logic                              s1_vld_reg;
    logic                              s2_vld_reg;
    logic                              s3_vld_reg;
    logic                              s4_vld_reg;
    logic [31:0]                       s1_step_reg;
    logic [icas_pkg::LEVEL_W-1:0]      s1_lvl_reg;
    logic                              s1_ok_reg;
    logic [icas_pkg::PHASE_W-1:0]      s2_phase_reg;
    logic [icas_pkg::LEVEL_W-1:0]      s2_lvl_reg;
    logic [icas_pkg::SINE_MAG_W-1:0]   s3_mag_reg;
    logic                              s3_neg_reg;
    logic [icas_pkg::LEVEL_W-1:0]      s3_lvl_reg;
    logic signed [PROD_W-1:0]          s4_prod_reg;
    logic signed [ACC_W-1:0]           acc_reg;

    logic [PPROD_W-1:0]                phase_prod;
    logic [SINE_TABLE_BITS-1:0]        tab_idx;
    logic [1:0]                        quad;
    logic [SINE_TABLE_BITS-3:0]        qpart;
    logic [QA_W-1:0]                   rom_addr;
    logic [LPROD_W-1:0]                lvl_prod;
    logic [PROD_W-1:0]                 lvl_prod_ext;

    assign phase_prod = PPROD_W'(s1_step_reg) * PPROD_W'(idx1_reg);
    assign tab_idx    = s2_phase_reg[icas_pkg::PHASE_W-1 -: SINE_TABLE_BITS];
    assign quad       = tab_idx[SINE_TABLE_BITS-1 -: 2];
    assign qpart      = tab_idx[SINE_TABLE_BITS-3:0];
    assign rom_addr   = quad[0] ? (QA_W'(QSIZE) - {1'b0, qpart}) : {1'b0, qpart};
    assign lvl_prod   = LPROD_W'(s3_lvl_reg) * LPROD_W'(s3_mag_reg);
    assign lvl_prod_ext = {1'b0, lvl_prod};

    assign status.last_row = (row_cnt_reg == ROW_W'(ROWS - 1));
    assign status.busy     = s1_vld_reg || s2_vld_reg || s3_vld_reg || s4_vld_reg;

    // divide by row count
    logic                     sign_reg;
    logic [DIV_K-1:0]         mag_reg;
    logic [DIV_K-1:0]         qest_reg;
    logic [DIV_K-1:0]         prodq_reg;
    logic signed [icas_pkg::SAMPLE_W-1:0] sample_reg;
    logic [ACC_W-1:0]         acc_abs;
    logic [2*DIV_K-1:0]       recip_prod;
    logic [2*DIV_K-1:0]       back_prod;
    logic [DIV_K-1:0]         rem;
    logic [DIV_K-1:0]         quot;
    logic [DIV_K-1:0]         quot_signed;

    assign acc_abs     = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign recip_prod  = (2*DIV_K)'(mag_reg) * (2*DIV_K)'(RECIP);
    assign back_prod   = (2*DIV_K)'(qest_reg) * (2*DIV_K)'(ROWS);
    assign rem         = mag_reg - prodq_reg;
    assign quot        = (rem >= DIV_K'(ROWS)) ? (qest_reg + DIV_K'(1)) : qest_reg;
    assign quot_signed = sign_reg ? (-quot) : quot;
    assign sample      = sample_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load && row_in_range)
        begin
            lvl_mem[wr_idx] <= pixel[icas_pkg::PIXEL_W-1 -: icas_pkg::LEVEL_W];
        end
        s1_lvl_reg <= lvl_mem[row_cnt_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_vld_reg <= '0;
            row_cnt_reg <= '0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load && row_in_range)
            begin
                lvl_vld_reg[wr_idx] <= 1'b1;
            end
            if (cmd.start)
            begin
                row_cnt_reg <= '0;
            end
            else if (cmd.issue)
            begin
                row_cnt_reg <= row_cnt_reg + ROW_W'(1);
            end
            s1_vld_reg <= cmd.issue;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            idx1_reg <= IDX1_W'(sample_index) + IDX1_W'(1);
        end
        s1_step_reg  <= step_tab[row_cnt_reg];
        s1_ok_reg    <= lvl_vld_reg[row_cnt_reg];
        s2_phase_reg <= phase_prod[icas_pkg::PHASE_W-1:0];
        s2_lvl_reg   <= s1_ok_reg ? s1_lvl_reg : '0;
        s3_mag_reg   <= quarter_rom[rom_addr];
        s3_neg_reg   <= quad[1];
        s3_lvl_reg   <= s2_lvl_reg;
        s4_prod_reg  <= s3_neg_reg ? $signed(-lvl_prod_ext) : $signed(lvl_prod_ext);
        if (cmd.start)
        begin
            acc_reg <= '0;
        end
        else if (s4_vld_reg)
        begin
            acc_reg <= acc_reg + {{(ACC_W-PROD_W){s4_prod_reg[PROD_W-1]}}, s4_prod_reg};
        end
        if (cmd.div_abs)
        begin
            sign_reg <= acc_reg[ACC_W-1];
            mag_reg  <= acc_abs[DIV_K-1:0];
        end
        if (cmd.div_mul)
        begin
            qest_reg <= recip_prod[2*DIV_K-1:DIV_K];
        end
        if (cmd.div_back)
        begin
            prodq_reg <= back_prod[DIV_K-1:0];
        end
        if (cmd.push)
        begin
            sample_reg <= $signed(quot_signed[icas_pkg::SAMPLE_W-1:0]);
        end
    end

endmodule

`default_nettype wire

// ----- src/image_column_additive_synth.sv -----
// top level of the image column additive synthesiser: controller plus datapath
// depends on icas_pkg, icas_if, icas_ctrl and icas_datapath
//
//   channel  dir  fields                               transaction
//   items    in   mode, row, pixel, sample_index       load one row level or request a sample
//   results  out  sample (20 bit signed)               one audio sample per sample request
//
// a load leaves the controller idle; the next item is taken the cycle after
// a sample request walks all ROWS rows through one shared phase multiply and
// sine table, one row a cycle, drains a four-stage pipe, then runs a
// three-step divide by ROWS and pushes the sample into the output register
// once it is free; the next item is taken in the cycle after that push
// the level store is cleared by per-row valid bits at reset, no clearing pass
// results sit in an output register; a stalled sink holds a finished sample
// and blocks new items only once the next sample is ready to leave
`timescale 1ns / 1ps
`default_nettype none

module image_column_additive_synth
#(
    parameter int ROWS            = icas_pkg::ROWS_DEFAULT,
    parameter int SINE_TABLE_BITS = icas_pkg::SINE_TABLE_BITS_DEFAULT
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    icas_item_if.sink      items,
    icas_result_if.source  results
);

    icas_pkg::icas_cmd_t    cmd;
    icas_pkg::icas_status_t status;

    icas_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_mode   (items.mode),
        .in_ready  (items.ready),
        .out_ready (results.ready),
        .out_valid (results.valid),
        .status    (status),
        .cmd       (cmd)
    );

    icas_datapath
    #(
        .ROWS            (ROWS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .row          (items.row),
        .pixel        (items.pixel),
        .sample_index (items.sample_index),
        .sample       (results.sample)
    );

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// self-checking bench for image_column_additive_synth: directed table, then random
// column loads and sample requests checked against an in-bench additive-synthesis predictor
// depends on icas_pkg, icas_if and image_column_additive_synth from the rtl
`timescale 1ns / 1ps

module tb;

    localparam int ROW_FIELD_W   = icas_pkg::ROW_FIELD_W;
    localparam int PIXEL_W       = icas_pkg::PIXEL_W;
    localparam int INDEX_W       = icas_pkg::INDEX_W;
    localparam int SAMPLE_W      = icas_pkg::SAMPLE_W;
    localparam int LEVEL_W       = icas_pkg::LEVEL_W;

    localparam int N_ROWS        = icas_pkg::ROWS_DEFAULT;
    localparam int LUT_BITS      = icas_pkg::SINE_TABLE_BITS_DEFAULT;
    localparam int LUT_SIZE      = 1 << LUT_BITS;
    localparam int QUARTER       = 1 << (LUT_BITS - 2);
    localparam int ITEM_TARGET   = 1350;
    localparam int QUIET_TAIL    = 150;
    localparam int WATCHDOG_MAX  = 3000;
    localparam int N_DIRECTED    = 22;

    localparam logic [63:0] A4_HZ            = 64'd440;
    localparam logic [63:0] SAMPLE_RATE_HZ   = 64'd8000;
    localparam int unsigned A4_TONE          = 31;
    localparam logic [63:0] UP_RATIO_Q31     = 64'd2275179671;
    localparam logic [63:0] DOWN_RATIO_Q32   = 64'd4053909305;
    localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
    localparam logic [63:0] Q15_MAX          = 64'd32767;
    localparam logic [63:0] WORD_MASK        = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic                       mode;
        logic [ROW_FIELD_W-1:0]     row;
        logic [PIXEL_W-1:0]         pixel;
        logic [INDEX_W-1:0]         idx;
        logic                       fixed;
        logic signed [SAMPLE_W-1:0] fixed_sample;
    } stim_row_t;

    logic clk;
    logic rst_n;

    icas_item_if   items_ch ();
    icas_result_if results_ch ();

    image_column_additive_synth uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch)
    );

    logic [LEVEL_W-1:0]         row_level [N_ROWS];
    logic [31:0]                tone_step_tab [N_ROWS];
    int                         sine_lut [LUT_SIZE];
    logic signed [SAMPLE_W-1:0] expected_samples [$];

    bit                         cur_fixed;
    logic signed [SAMPLE_W-1:0] cur_fixed_val;
    int                         sent_count;
    bit                         quiet;
    bit                         idling_on;
    int                         err_count;
    int                         stall_left;
    int                         idle_cycles;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{icas_pkg::MODE_SAMPLE, 6'd0,  8'h00, 9'd0,   1'b1, 20'sd0},
        '{icas_pkg::MODE_SAMPLE, 6'd63, 8'hFF, 9'd511, 1'b1, 20'sd0},
        '{icas_pkg::MODE_LOAD,   6'd63, 8'hFF, 9'd511, 1'b0, 20'sd0},
        '{icas_pkg::MODE_LOAD,   6'd0,  8'hFF, 9'd0,   1'b0, 20'sd0},
        '{icas_pkg::MODE_SAMPLE, 6'd0,  8'h00, 9'd0,   1'b0, 20'sd0},
        '{icas_pkg::MODE_SAMPLE, 6'd0,  8'h00, 9'd499, 1'b0, 20'sd0},
        '{icas_pkg::MODE_SAMPLE, 6'd0,  8'h00, 9'd500, 1'b0, 20'sd0},
        '{icas_pkg::MODE_SAMPLE, 6'd0,  8'h00, 9'd511, 1'b0, 20'sd0},
        '{icas_pkg::MODE_LOAD,   6'd32, 8'h0F, 9'd0,   1'b0, 20'sd0},
        '{icas_pkg::MODE_SAMPLE, 6'd0,  8'h00, 9'd7,   1'b0, 20'sd0},
        '{icas_pkg::MODE_LOAD,   6'd32, 8'hF0, 9'd0,   1'b0, 20'sd0},
        '{icas_pkg::MODE_SAMPLE, 6'd17, 8'hAA, 9'd19,  1'b0, 20'sd0},
        '{icas_pkg::MODE_LOAD,   6'd1,  8'h80, 9'h155, 1'b0, 20'sd0},
        '{icas_pkg::MODE_LOAD,   6'd62, 8'h7F, 9'h0AA, 1'b0, 20'sd0},
        '{icas_pkg::MODE_SAMPLE, 6'd0,  8'h00, 9'd1,   1'b0, 20'sd0},
        '{icas_pkg::MODE_SAMPLE, 6'd0,  8'h00, 9'd255, 1'b0, 20'sd0},
        '{icas_pkg::MODE_LOAD,   6'd0,  8'h00, 9'd0,   1'b0, 20'sd0},
        '{icas_pkg::MODE_LOAD,   6'd63, 8'h00, 9'd0,   1'b0, 20'sd0},
        '{icas_pkg::MODE_LOAD,   6'd32, 8'h00, 9'd0,   1'b0, 20'sd0},
        '{icas_pkg::MODE_LOAD,   6'd1,  8'h00, 9'd0,   1'b0, 20'sd0},
        '{icas_pkg::MODE_LOAD,   6'd62, 8'h00, 9'd0,   1'b0, 20'sd0},
        '{icas_pkg::MODE_SAMPLE, 6'd0,  8'h00, 9'd300, 1'b1, 20'sd0}
    };

    function automatic logic [31:0] semitone_step(input int unsigned tone);
        logic [63:0] s;
        int unsigned k;
        s = (A4_HZ << 32) / SAMPLE_RATE_HZ;
        if (tone >= A4_TONE)
        begin
            for (k = A4_TONE; k < tone; k++)
            begin
                s = ((s * UP_RATIO_Q31 + (64'd1 << 30)) >> 31) & WORD_MASK;
            end
        end
        else
        begin
            for (k = tone; k < A4_TONE; k++)
            begin
                s = ((s * DOWN_RATIO_Q32 + (64'd1 << 31)) >> 32) & WORD_MASK;
            end
        end
        return s[31:0];
    endfunction

    // taylor series through x^11 in q30, scaled to q1.15
    function automatic int quarter_mag(input int unsigned q);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] total;
        logic [63:0] v;
        int unsigned n;
        x     = (QUARTER_TURN_Q30 * 64'(q)) >> (LUT_BITS - 2);
        x2    = (x * x) >> 30;
        term  = x;
        total = x;
        for (n = 1; n <= 5; n++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
            begin
                total = total - term;
            end
            else
            begin
                total = total + term;
            end
        end
        v = (total * Q15_MAX + (64'd1 << 29)) >> 30;
        if (v > Q15_MAX)
        begin
            v = Q15_MAX;
        end
        return int'(v[15:0]);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] column_sample(input logic [INDEX_W-1:0] idx);
        longint      acc;
        longint      res;
        logic [63:0] prod;
        logic [31:0] phase;
        int          r;
        acc = 0;
        for (r = 0; r < N_ROWS; r++)
        begin
            prod  = 64'(tone_step_tab[N_ROWS - 1 - r]) * (64'(idx) + 64'd1);
            phase = prod[31:0];
            acc   = acc + longint'(row_level[r]) * longint'(sine_lut[phase[31:32-LUT_BITS]]);
        end
        res = acc / N_ROWS;
        return res[SAMPLE_W-1:0];
    endfunction

    task automatic send_item(input logic m, input logic [ROW_FIELD_W-1:0] r,
                             input logic [PIXEL_W-1:0] p, input logic [INDEX_W-1:0] idx,
                             input bit fixed, input logic signed [SAMPLE_W-1:0] fval);
        int gap;
        gap = 0;
        if (idling_on && !quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 14);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            items_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        items_ch.valid        <= 1'b1;
        items_ch.mode         <= m;
        items_ch.row          <= r;
        items_ch.pixel        <= p;
        items_ch.sample_index <= idx;
        cur_fixed     = fixed;
        cur_fixed_val = fval;
        @(posedge clk);
        while (!items_ch.ready)
        begin
            @(posedge clk);
        end
        sent_count++;
        quiet = (sent_count >= ITEM_TARGET - QUIET_TAIL);
    endtask

    task automatic send_random(input logic m, input logic [PIXEL_W-1:0] p,
                               input logic [ROW_FIELD_W-1:0] r);
        send_item(m, r, p, INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1)), 1'b0, '0);
    endtask

    task automatic drain_results();
        @(negedge clk);
        items_ch.valid <= 1'b0;
        while (expected_samples.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sink side with random stall bursts
    initial
    begin
        results_ch.ready <= 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && idling_on && !quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 14);
            end
            if (stall_left > 0)
            begin
                results_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                results_ch.ready <= 1'b1;
            end
        end
    end

    // transaction monitor and scoreboard
    always @(posedge clk)
    begin
        logic signed [SAMPLE_W-1:0] want;
        if (rst_n)
        begin
            if (results_ch.valid && results_ch.ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    $error("sample: unexpected result %0d", results_ch.sample);
                    err_count++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (results_ch.sample !== want)
                    begin
                        $error("sample mismatch: expected %0d, actual %0d", want,
                               results_ch.sample);
                        err_count++;
                    end
                end
            end
            if (items_ch.valid && items_ch.ready)
            begin
                if (items_ch.mode == icas_pkg::MODE_LOAD)
                begin
                    row_level[items_ch.row] = items_ch.pixel[PIXEL_W-1:PIXEL_W-LEVEL_W];
                end
                else if (cur_fixed)
                begin
                    expected_samples = {expected_samples, cur_fixed_val};
                end
                else
                begin
                    expected_samples = {expected_samples,
                                        column_sample(items_ch.sample_index)};
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_MAX)
            begin
                $display("status: fail");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        int i;
        int quad;
        int mag;
        int n;
        int kind;
        int episode;
        logic [PIXEL_W-1:0] p;

        rst_n                 <= 1'b0;
        items_ch.valid        <= 1'b0;
        items_ch.mode         <= icas_pkg::MODE_LOAD;
        items_ch.row          <= '0;
        items_ch.pixel        <= '0;
        items_ch.sample_index <= '0;
        cur_fixed     = 1'b0;
        cur_fixed_val = '0;
        sent_count    = 0;
        quiet         = 1'b0;
        idling_on     = 1'b1;
        err_count     = 0;

        for (i = 0; i < N_ROWS; i++)
        begin
            row_level[i]     = '0;
            tone_step_tab[i] = semitone_step(i);
        end
        for (i = 0; i < LUT_SIZE; i++)
        begin
            quad = i / QUARTER;
            mag  = (quad % 2 == 1) ? quarter_mag(QUARTER - (i % QUARTER))
                                   : quarter_mag(i % QUARTER);
            sine_lut[i] = (quad >= 2) ? -mag : mag;
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < N_DIRECTED; i++)
        begin
            send_item(directed_rows[i].mode, directed_rows[i].row, directed_rows[i].pixel,
                      directed_rows[i].idx, directed_rows[i].fixed,
                      directed_rows[i].fixed_sample);
        end
        drain_results();

        episode = 0;
        while (sent_count < ITEM_TARGET)
        begin
            idling_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 5) == 0)
            begin
                // whole column, in row order
                kind = $urandom_range(0, 3);
                for (i = 0; i < N_ROWS; i++)
                begin
                    p = PIXEL_W'($urandom_range(0, 255));
                    if (kind == 2)
                    begin
                        p = 8'hFF;
                    end
                    else if (kind == 3)
                    begin
                        p[PIXEL_W-1:PIXEL_W-LEVEL_W] = '1;
                    end
                    send_random(icas_pkg::MODE_LOAD, p, ROW_FIELD_W'(i));
                end
            end
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n) send_random(icas_pkg::MODE_LOAD, PIXEL_W'($urandom_range(0, 255)),
                                       ROW_FIELD_W'($urandom_range(0, N_ROWS - 1)));
            end
            n = $urandom_range(1, 6);
            repeat (n) send_random(icas_pkg::MODE_SAMPLE, PIXEL_W'($urandom_range(0, 255)),
                                   ROW_FIELD_W'($urandom_range(0, N_ROWS - 1)));
            episode++;
            if (episode % 40 == 20)
            begin
                drain_results();
            end
        end

        drain_results();
        repeat (N_ROWS + 20) @(negedge clk);
        if (err_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/icas_pkg.sv
src/icas_if.sv
src/icas_ctrl.sv
src/icas_datapath.sv
src/image_column_additive_synth.sv
bench/tb.sv
